[rtl/core/tpag_pkg.sv]
// tpag_pkg: shared types and constants for the tensor permute address generator
// no dependencies; used by every module of the block

package tpag_pkg;

   // control register indexes on the csr port
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_DIMS  = 2'd0,
      CSR_DIM_SIZES = 2'd1,
      CSR_DIM_ORDER = 2'd2
   } csr_reg_type;

   // width of the num_dims register and of its saturated copy
   localparam int NUM_DIMS_W = 3;
   localparam int USED_W     = 4;

   // status from the configuration block to the walker
   typedef struct packed {
      logic busy;   // stride sweep running, no transaction taken
      logic empty;  // some used dimension has size zero
   } tpag_ctl_type;

endpackage

[rtl/core/tensor_permute_address_gen.sv]
// One source index per transaction, one transaction per clock when rsp_ready stays high:
// the run counters and the result register update together on every accepted request, so
// outside the sweep req_ready drops only while a result waits unaccepted. After reset and
// after every write to a known control register the block runs a stride sweep
// (one multiply per cycle for the cumulative products, then one order position per
// cycle) during which req_ready is low; a write also restarts the run from position zero.
//
// tensor_permute_address_gen: top level, joins the configuration block and the walker
// depends on tpag_pkg, tpag_cfg, tpag_walk

module tensor_permute_address_gen #(
   parameter int MAX_DIMS   = 4,
   parameter int DIM_BITS   = 9,
   parameter int INDEX_BITS = 32,
   localparam int ORD_BITS  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
   localparam int SIZES_W   = MAX_DIMS * DIM_BITS,
   localparam int ORDER_W   = MAX_DIMS * ORD_BITS,
   localparam int WIDE_W    = (SIZES_W > ORDER_W) ? SIZES_W : ORDER_W,
   localparam int CSR_W     = (WIDE_W > tpag_pkg::NUM_DIMS_W) ? WIDE_W : tpag_pkg::NUM_DIMS_W
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_restart,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [INDEX_BITS-1:0]           rsp_src_index,
   output logic                            rsp_last,
   output logic                            rsp_empty_res,
   input  logic                            csr_write_en,
   input  logic [tpag_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]                csr_wdata
);

   localparam int OUTER    = (MAX_DIMS > 1) ? MAX_DIMS - 1 : 1;

   tpag_pkg::tpag_ctl_type  ctl;
   logic [DIM_BITS-1:0]     inner_size;
   logic [INDEX_BITS-1:0]   inner_stride;
   logic [DIM_BITS-1:0]     lvl_size [OUTER];
   logic [INDEX_BITS-1:0]   lvl_stride [OUTER];

   tpag_cfg #(
      .MAX_DIMS   (MAX_DIMS),
      .DIM_BITS   (DIM_BITS),
      .INDEX_BITS (INDEX_BITS),
      .ORD_BITS   (ORD_BITS),
      .CSR_W      (CSR_W),
      .OUTER      (OUTER)
   ) u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .ctl          (ctl),
      .inner_size   (inner_size),
      .inner_stride (inner_stride),
      .lvl_size     (lvl_size),
      .lvl_stride   (lvl_stride)
   );

   tpag_walk #(
      .DIM_BITS   (DIM_BITS),
      .INDEX_BITS (INDEX_BITS),
      .OUTER      (OUTER)
   ) u_walk (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .inner_size    (inner_size),
      .inner_stride  (inner_stride),
      .lvl_size      (lvl_size),
      .lvl_stride    (lvl_stride),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_src_index (rsp_src_index),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res)
   );

endmodule

[rtl/core/tpag_cfg.sv]
// tpag_cfg: control registers, stride sweep and per-level size/stride tables
// depends on tpag_pkg

module tpag_cfg #(
   parameter int MAX_DIMS   = 4,
   parameter int DIM_BITS   = 9,
   parameter int INDEX_BITS = 32,
   parameter int ORD_BITS   = 2,
   parameter int CSR_W      = 36,
   parameter int OUTER      = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [tpag_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]                csr_wdata,
   output tpag_pkg::tpag_ctl_type          ctl,
   output logic [DIM_BITS-1:0]             inner_size,
   output logic [INDEX_BITS-1:0]           inner_stride,
   output logic [DIM_BITS-1:0]             lvl_size [OUTER],
   output logic [INDEX_BITS-1:0]           lvl_stride [OUTER]
);

   localparam int SIZES_W   = MAX_DIMS * DIM_BITS;
   localparam int ORDER_W   = MAX_DIMS * ORD_BITS;
   localparam int STEP_W    = (2 * MAX_DIMS > 1) ? $clog2(2 * MAX_DIMS) : 1;
   localparam int OUT_IDX_W = (OUTER > 1) ? $clog2(OUTER) : 1;
   localparam int PROD_W    = INDEX_BITS + DIM_BITS;

   // identity order: entry p holds p
   function automatic logic [ORDER_W-1:0] identity_order();
      logic [ORDER_W-1:0] v;
      v = '0;
      for (int p = 0; p < MAX_DIMS; p++) begin
         v[p*ORD_BITS +: ORD_BITS] = ORD_BITS'(p);
      end
      return v;
   endfunction

   localparam logic [ORDER_W-1:0] ORDER_RESET = identity_order();

   logic [tpag_pkg::NUM_DIMS_W-1:0] num_dims_ff;
   logic [SIZES_W-1:0]              dim_sizes_ff;
   logic [ORDER_W-1:0]              dim_order_ff;

   logic                    busy_ff;
   logic                    empty_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [INDEX_BITS-1:0]   acc_ff;
   logic [INDEX_BITS-1:0]   stride_ff [MAX_DIMS];
   logic [DIM_BITS-1:0]     inner_size_ff;
   logic [INDEX_BITS-1:0]   inner_stride_ff;
   logic [DIM_BITS-1:0]     lvl_size_ff [OUTER];
   logic [INDEX_BITS-1:0]   lvl_stride_ff [OUTER];

   logic                    cfg_hit;
   logic [tpag_pkg::USED_W-1:0] used;
   logic                    phase_b;
   logic [ORD_BITS-1:0]     k_idx;
   logic [STEP_W-1:0]       p_full;
   logic [ORD_BITS-1:0]     p_idx;
   logic [OUT_IDX_W-1:0]    lvl_idx;
   logic [DIM_BITS-1:0]     field_a;
   logic [DIM_BITS-1:0]     size_a;
   logic [ORD_BITS-1:0]     ord_raw;
   logic [ORD_BITS-1:0]     ord_p;
   logic [DIM_BITS-1:0]     field_b;
   logic [DIM_BITS-1:0]     size_b;
   logic [INDEX_BITS-1:0]   stride_b;
   logic [PROD_W-1:0]       prod;
   logic                    k_used;
   logic                    p_used;
   logic                    one_dim;

   always_comb begin
      cfg_hit = csr_write_en &&
                (csr_index == tpag_pkg::CSR_NUM_DIMS ||
                 csr_index == tpag_pkg::CSR_DIM_SIZES ||
                 csr_index == tpag_pkg::CSR_DIM_ORDER);

      // num_dims above the supported count saturates
      if ({1'b0, num_dims_ff} > tpag_pkg::USED_W'(MAX_DIMS)) begin
         used = tpag_pkg::USED_W'(MAX_DIMS);
      end else begin
         used = {1'b0, num_dims_ff};
      end
      one_dim = (used == tpag_pkg::USED_W'(1));

      phase_b = (step_ff >= STEP_W'(MAX_DIMS));
      k_idx   = ORD_BITS'(step_ff);
      p_full  = step_ff - STEP_W'(MAX_DIMS);
      p_idx   = ORD_BITS'(p_full);
      lvl_idx = OUT_IDX_W'(p_full - STEP_W'(1));

      // sweep phase a: stride of dimension k and running product
      k_used  = (tpag_pkg::USED_W'(k_idx) < used);
      field_a = dim_sizes_ff[k_idx*DIM_BITS +: DIM_BITS];
      size_a  = k_used ? field_a : DIM_BITS'(1);
      prod    = {{DIM_BITS{1'b0}}, acc_ff} * {{INDEX_BITS{1'b0}}, size_a};

      // sweep phase b: dimension named at order position p, out of range wraps
      ord_raw = dim_order_ff[p_idx*ORD_BITS +: ORD_BITS];
      if ({1'b0, ord_raw} >= (ORD_BITS+1)'(MAX_DIMS)) begin
         ord_p = ORD_BITS'({1'b0, ord_raw} - (ORD_BITS+1)'(MAX_DIMS));
      end else begin
         ord_p = ord_raw;
      end
      field_b  = dim_sizes_ff[ord_p*DIM_BITS +: DIM_BITS];
      size_b   = (tpag_pkg::USED_W'(ord_p) < used) ? field_b : DIM_BITS'(1);
      stride_b = stride_ff[ord_p];
      p_used   = (tpag_pkg::USED_W'(p_idx) < used);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff  <= tpag_pkg::NUM_DIMS_W'(1);
         dim_sizes_ff <= SIZES_W'(1);
         dim_order_ff <= ORDER_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            tpag_pkg::CSR_NUM_DIMS:  num_dims_ff  <= csr_wdata[tpag_pkg::NUM_DIMS_W-1:0];
            tpag_pkg::CSR_DIM_SIZES: dim_sizes_ff <= csr_wdata[SIZES_W-1:0];
            tpag_pkg::CSR_DIM_ORDER: dim_order_ff <= csr_wdata[ORDER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         busy_ff  <= 1'b1;
         empty_ff <= 1'b0;
         step_ff  <= '0;
         acc_ff   <= INDEX_BITS'(1);
         for (int k = 0; k < OUTER; k++) begin
            lvl_size_ff[k] <= DIM_BITS'(1);
         end
      end else if (busy_ff) begin
         if (!phase_b) begin
            stride_ff[k_idx] <= acc_ff;
            acc_ff           <= prod[INDEX_BITS-1:0];
            empty_ff         <= empty_ff | (k_used && field_a == '0);
         end else if (p_idx == '0) begin
            // a single dimension ignores the order
            inner_size_ff   <= one_dim ? dim_sizes_ff[DIM_BITS-1:0] : size_b;
            inner_stride_ff <= one_dim ? INDEX_BITS'(1) : stride_b;
         end else begin
            lvl_size_ff[lvl_idx]   <= p_used ? size_b : DIM_BITS'(1);
            lvl_stride_ff[lvl_idx] <= stride_b;
         end
         if (step_ff == STEP_W'(2 * MAX_DIMS - 1)) begin
            busy_ff <= 1'b0;
         end else begin
            step_ff <= step_ff + STEP_W'(1);
         end
      end
   end

   assign ctl.busy     = busy_ff;
   assign ctl.empty    = empty_ff;
   assign inner_size   = inner_size_ff;
   assign inner_stride = inner_stride_ff;
   assign lvl_size     = lvl_size_ff;
   assign lvl_stride   = lvl_stride_ff;

endmodule

[rtl/core/tpag_walk.sv]
// tpag_walk: inner and outer run counters, index update and result register
// depends on tpag_pkg; tables come from tpag_cfg

module tpag_walk #(
   parameter int DIM_BITS   = 9,
   parameter int INDEX_BITS = 32,
   parameter int OUTER      = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tpag_pkg::tpag_ctl_type  ctl,
   input  logic [DIM_BITS-1:0]     inner_size,
   input  logic [INDEX_BITS-1:0]   inner_stride,
   input  logic [DIM_BITS-1:0]     lvl_size [OUTER],
   input  logic [INDEX_BITS-1:0]   lvl_stride [OUTER],
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_restart,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [INDEX_BITS-1:0]   rsp_src_index,
   output logic                    rsp_last,
   output logic                    rsp_empty_res
);

   logic [DIM_BITS-1:0]   inner_ff;
   logic [INDEX_BITS-1:0] cur_ff;
   logic [DIM_BITS-1:0]   outer_ff [OUTER];
   logic [INDEX_BITS-1:0] part_ff [OUTER];   // sum of counter*stride from level k up

   logic                  rsp_valid_ff;
   logic [INDEX_BITS-1:0] rsp_src_index_ff;
   logic                  rsp_last_ff;
   logic                  rsp_empty_res_ff;

   logic                  req_fire;
   logic [DIM_BITS-1:0]   inner_e;
   logic [INDEX_BITS-1:0] cur_e;
   logic [DIM_BITS-1:0]   outer_e [OUTER];
   logic [INDEX_BITS-1:0] part_e [OUTER];
   logic [DIM_BITS-1:0]   outer_in [OUTER];
   logic [INDEX_BITS-1:0] part_in [OUTER];
   logic [OUTER-1:0]      fin;
   logic [OUTER:0]        below;      // all levels under k at their final value
   logic                  inner_last;
   logic                  run_last;
   logic [INDEX_BITS-1:0] carry_sum;

   assign req_ready = !ctl.busy && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      inner_e = req_restart ? '0 : inner_ff;
      cur_e   = req_restart ? '0 : cur_ff;
      for (int k = 0; k < OUTER; k++) begin
         outer_e[k] = req_restart ? '0 : outer_ff[k];
         part_e[k]  = req_restart ? '0 : part_ff[k];
      end

      inner_last = ({1'b0, inner_e} + (DIM_BITS+1)'(1)) >= {1'b0, inner_size};
      below[0] = 1'b1;
      for (int k = 0; k < OUTER; k++) begin
         fin[k]     = ({1'b0, outer_e[k]} + (DIM_BITS+1)'(1)) >= {1'b0, lvl_size[k]};
         below[k+1] = below[k] & fin[k];
      end
      run_last = inner_last & below[OUTER];

      // odometer step: first unfinished level counts, levels under it restart
      carry_sum = '0;
      for (int k = OUTER - 1; k >= 0; k--) begin
         if (below[k] && !fin[k]) begin
            outer_in[k] = outer_e[k] + DIM_BITS'(1);
            part_in[k]  = part_e[k] + lvl_stride[k];
            carry_sum   = part_in[k];
         end else if (below[k]) begin
            outer_in[k] = '0;
            part_in[k]  = carry_sum;
         end else begin
            outer_in[k] = outer_e[k];
            part_in[k]  = part_e[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.busy) begin
         inner_ff <= '0;
         cur_ff   <= '0;
         for (int k = 0; k < OUTER; k++) begin
            outer_ff[k] <= '0;
            part_ff[k]  <= '0;
         end
      end else if (req_fire) begin
         if (ctl.empty || run_last) begin
            inner_ff <= '0;
            cur_ff   <= '0;
            for (int k = 0; k < OUTER; k++) begin
               outer_ff[k] <= '0;
               part_ff[k]  <= '0;
            end
         end else if (!inner_last) begin
            inner_ff <= inner_e + DIM_BITS'(1);
            cur_ff   <= cur_e + inner_stride;
            outer_ff <= outer_e;
            part_ff  <= part_e;
         end else begin
            inner_ff <= '0;
            cur_ff   <= part_in[0];
            outer_ff <= outer_in;
            part_ff  <= part_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_src_index_ff <= ctl.empty ? '0 : cur_e;
         rsp_last_ff      <= ctl.empty | run_last;
         rsp_empty_res_ff <= ctl.empty;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_src_index = rsp_src_index_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_res_ff;

endmodule

[rtl/core/tpag_checker.sv]
// tpag_checker: port-level assertions for the address generator, bound to the top level
// depends on tpag_pkg and tensor_permute_address_gen

module tpag_checker #(
   parameter int INDEX_BITS = 32,
   parameter int CSR_W      = 36
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_restart,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [INDEX_BITS-1:0]           rsp_src_index,
   input logic                            rsp_last,
   input logic                            rsp_empty_res,
   input logic                            csr_write_en,
   input logic [tpag_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_W-1:0]                csr_wdata
);

   // an empty mapping is a single final transaction at index zero
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last && rsp_src_index == '0)
      else $error("empty result without last or with nonzero index");

   // no transaction taken while strides are rebuilt after reset
   a_sweep_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken straight after reset");

   // a known register write restarts the stride sweep
   a_sweep_after_write: assert property (@(posedge clock) disable iff (reset)
      csr_write_en && (csr_index == tpag_pkg::CSR_NUM_DIMS ||
                       csr_index == tpag_pkg::CSR_DIM_SIZES ||
                       csr_index == tpag_pkg::CSR_DIM_ORDER) |=> !req_ready)
      else $error("request taken straight after a register write");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_src_index) &&
                                 $stable(rsp_last) && $stable(rsp_empty_res))
      else $error("stalled result changed");

endmodule

bind tensor_permute_address_gen tpag_checker #(
   .INDEX_BITS (INDEX_BITS),
   .CSR_W      (CSR_W)
) u_tpag_checker (.*);
